[rtl/fdl_pkg.sv]
// shared constants and types for the fractional delay line
package fdl_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int FRAC_BITS     = 8;
   localparam int DELAY_BITS    = 20;
   localparam int DEPTH_DEFAULT = 4096;
   localparam int QDEPTH        = 4;
   localparam int QCNT_BITS     = $clog2(QDEPTH + 1);
   localparam int QPTR_BITS     = $clog2(QDEPTH);
   localparam int PROD_BITS     = SAMPLE_BITS + FRAC_BITS + 2;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] a;
      logic [SAMPLE_BITS-1:0] b;
      logic [FRAC_BITS-1:0]   frac;
   } fdl_entry_type;

   typedef struct packed {
      logic          valid;
      fdl_entry_type entry;
   } fdl_slot_type;

endpackage

[rtl/fdl_req_if.sv]
// input sample channel
interface fdl_req_if import fdl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink (input valid, input in_sample, output ready);
endinterface

[rtl/fdl_rsp_if.sv]
// delayed sample result channel
interface fdl_rsp_if import fdl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] delayed_sample;

   modport source (output valid, output delayed_sample, input ready);
   modport sink (input valid, input delayed_sample, output ready);
endinterface

[rtl/fdl_front.sv]
// front end: delay register, sample store, read position and neighbor reads
module fdl_front import fdl_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [DELAY_BITS-1:0] csr_wdata,
   fdl_req_if.sink               req_if,
   input  logic [QCNT_BITS-1:0]  q_count,
   output fdl_slot_type          push
);

   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW        = AW + FRAC_BITS;
   localparam int SPAN      = DEPTH * (2 ** FRAC_BITS);
   localparam int DELAY_MAX = (DEPTH - 1) * (2 ** FRAC_BITS) - 1;

   logic [SAMPLE_BITS-1:0] sample_store [DEPTH];

   logic [AW-1:0]          w_ff, w_in;
   logic                   wrapped_ff, wrapped_in;
   logic [PW-1:0]          delay_ff, delay_in;
   logic                   s1_valid_ff;
   logic                   a_ok_ff, b_ok_ff;
   logic [FRAC_BITS-1:0]   frac_ff;
   logic [SAMPLE_BITS-1:0] a_raw_ff, b_raw_ff;

   logic                   accept;
   logic [PW-1:0]          wpos;
   logic [PW:0]            pos_wrap;
   logic [PW-1:0]          pos;
   logic [AW-1:0]          ia, ib;

   assign req_if.ready = (q_count + QCNT_BITS'(s1_valid_ff)) < QCNT_BITS'(QDEPTH);
   assign accept       = req_if.valid && req_if.ready;

   // read position relative to the write index, modulo the store span
   assign wpos     = {w_ff, {FRAC_BITS{1'b0}}};
   assign pos_wrap = {1'b0, wpos} + (PW+1)'(SPAN) - {1'b0, delay_ff};
   assign pos      = (wpos >= delay_ff) ? (wpos - delay_ff) : pos_wrap[PW-1:0];
   assign ia       = pos[PW-1:FRAC_BITS];
   assign ib       = (ia == AW'(DEPTH - 1)) ? '0 : ia + 1'b1;

   always_comb begin
      delay_in = delay_ff;
      if (csr_we) begin
         delay_in = (int'(csr_wdata) > DELAY_MAX) ? PW'(DELAY_MAX) : PW'(csr_wdata);
      end
      w_in       = w_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         if (w_ff == AW'(DEPTH - 1)) begin
            w_in       = '0;
            wrapped_in = 1'b1;
         end else begin
            w_in = w_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff        <= '0;
         wrapped_ff  <= 1'b0;
         delay_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         w_ff        <= w_in;
         wrapped_ff  <= wrapped_in;
         delay_ff    <= delay_in;
         s1_valid_ff <= accept;
      end
   end

   // entries not yet written since reset read as zero
   always_ff @(posedge clock) begin
      if (accept) begin
         a_ok_ff <= wrapped_ff || (ia < w_ff);
         b_ok_ff <= wrapped_ff || (ib < w_ff);
         frac_ff <= pos[FRAC_BITS-1:0];
      end
   end

   // reads see the store before this transaction's write
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_store[w_ff] <= req_if.in_sample;
         a_raw_ff           <= sample_store[ia];
         b_raw_ff           <= sample_store[ib];
      end
   end

   always_comb begin
      push.valid      = s1_valid_ff;
      push.entry.a    = a_ok_ff ? a_raw_ff : '0;
      push.entry.b    = b_ok_ff ? b_raw_ff : '0;
      push.entry.frac = frac_ff;
   end

`ifndef NO_ASSERTIONS
   a_accept_pushes: assert property (@(posedge clock) disable iff (reset)
      accept |=> push.valid)
      else $error("accepted transaction did not reach the queue");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(wrapped_ff)) |-> wrapped_ff)
      else $error("store fill flag cleared outside reset");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> ((q_count + QCNT_BITS'(s1_valid_ff)) < QCNT_BITS'(QDEPTH)))
      else $error("transaction accepted without queue room");
`endif

endmodule

[rtl/fdl_queue.sv]
// short queue between the read front end and the interpolation back end
module fdl_queue import fdl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  fdl_slot_type         push,
   input  logic                 pop,
   output fdl_slot_type         head,
   output logic [QCNT_BITS-1:0] count
);

   fdl_entry_type          slots [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots[wr_ptr_ff] <= push.entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = slots[rd_ptr_ff];
   assign count      = count_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && !pop && (count_ff == QCNT_BITS'(QDEPTH))))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue underflow");
`endif

endmodule

[rtl/fdl_back.sv]
// back end: linear interpolation pipeline and result register
module fdl_back import fdl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  fdl_slot_type head,
   output logic         pop,
   fdl_rsp_if.source    rsp_if
);

   logic                         m_valid_ff;
   logic signed [PROD_BITS-1:0]  m_prod_ff;
   logic [SAMPLE_BITS-1:0]       m_a_ff;
   logic                         o_valid_ff;
   logic [SAMPLE_BITS-1:0]       o_data_ff;

   logic                         en_o, en_m;
   logic signed [SAMPLE_BITS:0]  diff;
   logic signed [PROD_BITS-1:0]  prod_in;
   logic [SAMPLE_BITS+1:0]       sum;

   assign en_o = !o_valid_ff || rsp_if.ready;
   assign en_m = !m_valid_ff || en_o;
   assign pop  = head.valid && en_m;

   assign diff    = $signed({head.entry.b[SAMPLE_BITS-1], head.entry.b})
                  - $signed({head.entry.a[SAMPLE_BITS-1], head.entry.a});
   assign prod_in = diff * $signed({1'b0, head.entry.frac});

   // arithmetic shift of the product floors toward minus infinity
   assign sum = {{2{m_a_ff[SAMPLE_BITS-1]}}, m_a_ff} + m_prod_ff[PROD_BITS-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (en_m) begin
            m_valid_ff <= head.valid;
         end
         if (en_o) begin
            o_valid_ff <= m_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         m_prod_ff <= prod_in;
         m_a_ff    <= head.entry.a;
      end
      if (en_o && m_valid_ff) begin
         o_data_ff <= sum[SAMPLE_BITS-1:0];
      end
   end

   assign rsp_if.valid          = o_valid_ff;
   assign rsp_if.delayed_sample = o_data_ff;

`ifndef NO_ASSERTIONS
   a_mul_hold: assert property (@(posedge clock) disable iff (reset)
      (m_valid_ff && !en_m) |=> (m_valid_ff && $stable(m_prod_ff)))
      else $error("interpolation stage lost a transaction under stall");
`endif

endmodule

[rtl/fractional_delay_line_top.sv]
// fractional delay line top level
// Takes one signed sample transaction per clock while the queue has room, and returns one
// linearly interpolated sample per transaction, in order, through the store read, queue,
// multiply and result register. The dual-read sample store reads both neighbors and writes
// the new sample in the same cycle; a stalled result side fills the four-entry queue and
// then holds off the input. The delay register csr_wdata is in samples with 8 fraction bits
// and saturates just below DEPTH - 1; write it only while no transaction is in flight. After
// reset the store reads as zero through a fill flag on the write index, so no clearing pass
// is needed and input is taken at once.
module fractional_delay_line_top import fdl_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [DELAY_BITS-1:0] csr_wdata,
   fdl_req_if.sink               req_if,
   fdl_rsp_if.source             rsp_if
);

   fdl_slot_type          push;
   fdl_slot_type          head;
   logic                  pop;
   logic [QCNT_BITS-1:0]  q_count;

   fdl_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .q_count   (q_count),
      .push      (push)
   );

   fdl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   fdl_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule
